// File: sv/c_bracket_balance_checker_core_macros.svh
// assertion helpers shared by the checker modules
`ifndef C_BRACKET_BALANCE_CHECKER_CORE_MACROS_SVH
`define C_BRACKET_BALANCE_CHECKER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define BCB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define BCB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/bcb_pkg.sv
package bcb_pkg;

	localparam int BALANCE_WIDTH = 16;

	typedef logic [BALANCE_WIDTH-1:0] bal_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	localparam logic [1:0] KIND_PAREN   = 2'd0;
	localparam logic [1:0] KIND_BRACKET = 2'd1;
	localparam logic [1:0] KIND_BRACE   = 2'd2;

	localparam logic [1:0] REG_PLAIN   = 2'd0;
	localparam logic [1:0] REG_QUOTE   = 2'd1;
	localparam logic [1:0] REG_COMMENT = 2'd2;

	// balance update request from the scanner to the tally
	typedef struct packed {
		logic       count_en;
		logic [1:0] kind;
		logic       opening;
		logic [1:0] region;
		logic       wipe_quote;
		logic       wipe_comment;
	} bcb_cmd_t;

endpackage

// File: sv/c_bracket_balance_checker_core.sv
// channel  | handshake           | word
// ---------+---------------------+----------------------------------------------
// in       | in_valid / in_ready | text_byte, end_of_text
// out      | out_valid/out_ready | paren_/bracket_/brace_unmatched, all_matched
//
// one byte per cycle sustained while the input stage does not hold; the last byte goes
// through the input register, then scan and tally into the result register
// reset clears the mode flags and the balances at once, no clearing pass
// the input stage holds only while a result still waits in the result register
// and the held byte is itself a last byte
`include "c_bracket_balance_checker_core_macros.svh"

module c_bracket_balance_checker_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       paren_unmatched,
	output logic       bracket_unmatched,
	output logic       brace_unmatched,
	output logic       all_matched
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              advance;
	logic              out_valid_q;
	logic [2:0]        unmatched_q;
	logic [2:0]        unmatched;
	bcb_pkg::bcb_cmd_t cmd;

	assign advance = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
			last_s1 <= end_of_text;
		end
	end

	bcb_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.text_byte   (byte_s1),
		.end_of_text (last_s1),
		.cmd         (cmd)
	);

	bcb_tally u_tally (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.end_of_text (last_s1),
		.cmd         (cmd),
		.unmatched   (unmatched)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			unmatched_q <= unmatched;
		end
	end

	assign out_valid = out_valid_q;
	assign paren_unmatched = unmatched_q[0];
	assign bracket_unmatched = unmatched_q[1];
	assign brace_unmatched = unmatched_q[2];
	assign all_matched = ~|unmatched_q;

	`BCB_ASSERT_NOW(a_stall_cause, !in_ready,
		valid_s1 && last_s1 && out_valid_q && !out_ready, "input stalled without cause")
	`BCB_ASSERT_NEXT(a_result_loaded, advance && last_s1, out_valid,
		"last word did not produce a result")
	`BCB_ASSERT_NOW(a_flags_agree, out_valid,
		all_matched == !(paren_unmatched || bracket_unmatched || brace_unmatched),
		"summary flag disagrees with kind flags")

endmodule

// File: sv/bcb_scan.sv
`include "c_bracket_balance_checker_core_macros.svh"

module bcb_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       text_byte,
	input  logic             end_of_text,
	output bcb_pkg::bcb_cmd_t cmd
);

	logic esc_q, iq_q, ic_q, ciq_q, qic_q, ps_q, pst_q;
	logic esc_n, iq_n, ic_n, ciq_n, qic_n, ps_n, pst_n;
	logic do_fresh;
	logic is_bracket;

	always_comb begin
		esc_n = esc_q;
		iq_n = iq_q;
		ic_n = ic_q;
		ciq_n = ciq_q;
		qic_n = qic_q;
		// at most one lookahead flag is ever set, and it is consumed by this byte
		ps_n = 1'b0;
		pst_n = 1'b0;
		do_fresh = 1'b0;
		is_bracket = 1'b0;
		cmd = '0;

		priority if (ps_q) begin
			if (text_byte == bcb_pkg::CH_STAR) begin
				// comment opener
				priority if (iq_q) begin
					iq_n = 1'b0;
					ciq_n = 1'b1;
				end else if (!ciq_q && !qic_q) begin
					ic_n = 1'b1;
				end else begin
				end
			end else begin
				do_fresh = 1'b1;
			end
		end else if (pst_q) begin
			if (text_byte == bcb_pkg::CH_SLASH) begin
				// comment closer
				priority if (ic_q) begin
					ic_n = 1'b0;
					cmd.wipe_comment = 1'b1;
				end else if (ciq_q) begin
					ciq_n = 1'b0;
					iq_n = 1'b1;
					cmd.wipe_comment = 1'b1;
				end else if (qic_q) begin
					qic_n = 1'b0;
					cmd.wipe_comment = 1'b1;
					cmd.wipe_quote = 1'b1;
				end else begin
				end
			end else begin
				do_fresh = 1'b1;
			end
		end else begin
			do_fresh = 1'b1;
		end

		if (do_fresh) begin
			priority if (text_byte == bcb_pkg::CH_BSLASH) begin
				esc_n = 1'b1;
			end else if (!esc_q && text_byte == bcb_pkg::CH_QUOTE) begin
				priority if (ic_q) begin
					ic_n = 1'b0;
					qic_n = 1'b1;
				end else if (ciq_q) begin
					ciq_n = 1'b0;
					cmd.wipe_quote = 1'b1;
					cmd.wipe_comment = 1'b1;
				end else if (qic_q) begin
					qic_n = 1'b0;
					ic_n = 1'b1;
					cmd.wipe_quote = 1'b1;
				end else if (iq_q) begin
					iq_n = 1'b0;
					cmd.wipe_quote = 1'b1;
				end else begin
					iq_n = 1'b1;
				end
			end else if (!esc_q && text_byte == bcb_pkg::CH_SLASH) begin
				ps_n = 1'b1;
			end else if (!esc_q && text_byte == bcb_pkg::CH_STAR
					&& (ic_q || ciq_q || qic_q)) begin
				pst_n = 1'b1;
			end else begin
				esc_n = 1'b0;
				is_bracket = 1'b1;
				unique case (text_byte)
					bcb_pkg::CH_LPAREN: begin
						cmd.kind = bcb_pkg::KIND_PAREN;
						cmd.opening = 1'b1;
					end
					bcb_pkg::CH_RPAREN: begin
						cmd.kind = bcb_pkg::KIND_PAREN;
					end
					bcb_pkg::CH_LBRACK: begin
						cmd.kind = bcb_pkg::KIND_BRACKET;
						cmd.opening = 1'b1;
					end
					bcb_pkg::CH_RBRACK: begin
						cmd.kind = bcb_pkg::KIND_BRACKET;
					end
					bcb_pkg::CH_LBRACE: begin
						cmd.kind = bcb_pkg::KIND_BRACE;
						cmd.opening = 1'b1;
					end
					bcb_pkg::CH_RBRACE: begin
						cmd.kind = bcb_pkg::KIND_BRACE;
					end
					default: begin
						is_bracket = 1'b0;
					end
				endcase
				cmd.count_en = is_bracket;
				priority if (ic_q || ciq_q) begin
					cmd.region = bcb_pkg::REG_COMMENT;
				end else if (iq_q || qic_q) begin
					cmd.region = bcb_pkg::REG_QUOTE;
				end else begin
					cmd.region = bcb_pkg::REG_PLAIN;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
			iq_q <= 1'b0;
			ic_q <= 1'b0;
			ciq_q <= 1'b0;
			qic_q <= 1'b0;
			ps_q <= 1'b0;
			pst_q <= 1'b0;
		end else if (step) begin
			// the last word returns every mode flag to its idle value
			esc_q <= esc_n && !end_of_text;
			iq_q <= iq_n && !end_of_text;
			ic_q <= ic_n && !end_of_text;
			ciq_q <= ciq_n && !end_of_text;
			qic_q <= qic_n && !end_of_text;
			ps_q <= ps_n && !end_of_text;
			pst_q <= pst_n && !end_of_text;
		end
	end

	`BCB_ASSERT_NOW(a_one_lookahead, 1'b1, !(ps_q && pst_q), "both lookahead flags set")
	`BCB_ASSERT_NOW(a_count_excl_wipe, step && cmd.count_en,
		!cmd.wipe_quote && !cmd.wipe_comment, "count and wipe in the same word")

endmodule

// File: sv/bcb_tally.sv
module bcb_tally (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              end_of_text,
	input  bcb_pkg::bcb_cmd_t cmd,
	output logic [2:0]        unmatched
);

	bcb_pkg::bal_t plain_q [3];
	bcb_pkg::bal_t quote_q [3];
	bcb_pkg::bal_t comment_q [3];
	bcb_pkg::bal_t plain_n [3];
	bcb_pkg::bal_t quote_n [3];
	bcb_pkg::bal_t comment_n [3];
	bcb_pkg::bal_t delta;
	bcb_pkg::bal_t total;

	// +1 for an opener, -1 for a closer, wrapping
	assign delta = cmd.opening ? bcb_pkg::bal_t'(1) : '1;

	always_comb begin
		total = '0;
		for (int k = 0; k < 3; k++) begin
			plain_n[k] = plain_q[k];
			quote_n[k] = cmd.wipe_quote ? '0 : quote_q[k];
			comment_n[k] = cmd.wipe_comment ? '0 : comment_q[k];
			if (cmd.count_en && cmd.kind == 2'(k)) begin
				unique case (cmd.region)
					bcb_pkg::REG_PLAIN:   plain_n[k] = plain_q[k] + delta;
					bcb_pkg::REG_QUOTE:   quote_n[k] = quote_q[k] + delta;
					bcb_pkg::REG_COMMENT: comment_n[k] = comment_q[k] + delta;
					default: begin
					end
				endcase
			end
			total = plain_n[k] + quote_n[k] + comment_n[k];
			unmatched[k] = |total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				plain_q[k] <= '0;
				quote_q[k] <= '0;
				comment_q[k] <= '0;
			end
		end else if (step) begin
			for (int k = 0; k < 3; k++) begin
				plain_q[k] <= end_of_text ? '0 : plain_n[k];
				quote_q[k] <= end_of_text ? '0 : quote_n[k];
				comment_q[k] <= end_of_text ? '0 : comment_n[k];
			end
		end
	end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 600;
	localparam int HOLD_AFTER  = 15;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       calm;
		logic       drain;
	} text_word_t;

	typedef struct packed {
		logic paren;
		logic bracket;
		logic brace;
		logic all;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] text_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       paren_unmatched;
	logic       bracket_unmatched;
	logic       brace_unmatched;
	logic       all_matched;

	text_word_t pend_q[$];
	logic [7:0] draft_q[$];
	verdict_t   verdict_q[$];

	// scanner state mirrored from the block
	logic esc_seen, quote_on, comment_on, cmt_in_quote, quote_in_cmt;
	logic slash_wait, star_wait;
	bcb_pkg::bal_t bal_tab[3][3];

	int errors = 0;
	int words_in = 0;
	int results_seen = 0;
	int total_words = 0;
	int tx_wait = 0;
	int rx_wait = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	bit hold_done = 1'b0;
	bit rx_calm = 1'b0;
	bit in_taken = 1'b0;
	text_word_t cur;
	string fld_names[4] = '{"all_matched", "brace_unmatched", "bracket_unmatched",
		"paren_unmatched"};

	c_bracket_balance_checker_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.text_byte        (text_byte),
		.end_of_text      (end_of_text),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.paren_unmatched  (paren_unmatched),
		.bracket_unmatched(bracket_unmatched),
		.brace_unmatched  (brace_unmatched),
		.all_matched      (all_matched)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic void wipe_region(input logic [1:0] rgn);
		for (int k = 0; k < 3; k++)
			bal_tab[rgn][k] = '0;
	endfunction

	function automatic void clear_scan();
		esc_seen = 1'b0;
		quote_on = 1'b0;
		comment_on = 1'b0;
		cmt_in_quote = 1'b0;
		quote_in_cmt = 1'b0;
		slash_wait = 1'b0;
		star_wait = 1'b0;
		wipe_region(bcb_pkg::REG_PLAIN);
		wipe_region(bcb_pkg::REG_QUOTE);
		wipe_region(bcb_pkg::REG_COMMENT);
	endfunction

	// advance the scanner by one byte; returns 1 with the verdict on the last byte
	function automatic bit scan_byte(input logic [7:0] c, input logic last,
		output verdict_t v);
		logic          fresh;
		logic          is_br;
		logic          opening;
		logic [1:0]    kind;
		logic [1:0]    rgn;
		logic [2:0]    bad;
		bcb_pkg::bal_t sum;
		fresh = 1'b1;
		is_br = 1'b1;
		opening = 1'b0;
		kind = bcb_pkg::KIND_PAREN;
		bad = '0;
		v = '0;
		if (slash_wait) begin
			slash_wait = 1'b0;
			if (c == bcb_pkg::CH_STAR) begin
				fresh = 1'b0;
				if (quote_on) begin
					quote_on = 1'b0;
					cmt_in_quote = 1'b1;
				end else if (!cmt_in_quote && !quote_in_cmt) begin
					comment_on = 1'b1;
				end
			end
		end else if (star_wait) begin
			star_wait = 1'b0;
			if (c == bcb_pkg::CH_SLASH) begin
				fresh = 1'b0;
				if (comment_on) begin
					comment_on = 1'b0;
					wipe_region(bcb_pkg::REG_COMMENT);
				end else if (cmt_in_quote) begin
					cmt_in_quote = 1'b0;
					quote_on = 1'b1;
					wipe_region(bcb_pkg::REG_COMMENT);
				end else if (quote_in_cmt) begin
					quote_in_cmt = 1'b0;
					wipe_region(bcb_pkg::REG_COMMENT);
					wipe_region(bcb_pkg::REG_QUOTE);
				end
			end
		end
		if (fresh) begin
			if (c == bcb_pkg::CH_BSLASH) begin
				esc_seen = 1'b1;
			end else if (!esc_seen && c == bcb_pkg::CH_QUOTE) begin
				if (comment_on) begin
					comment_on = 1'b0;
					quote_in_cmt = 1'b1;
				end else if (cmt_in_quote) begin
					cmt_in_quote = 1'b0;
					wipe_region(bcb_pkg::REG_QUOTE);
					wipe_region(bcb_pkg::REG_COMMENT);
				end else if (quote_in_cmt) begin
					quote_in_cmt = 1'b0;
					comment_on = 1'b1;
					wipe_region(bcb_pkg::REG_QUOTE);
				end else if (quote_on) begin
					quote_on = 1'b0;
					wipe_region(bcb_pkg::REG_QUOTE);
				end else begin
					quote_on = 1'b1;
				end
			end else if (!esc_seen && c == bcb_pkg::CH_SLASH) begin
				slash_wait = 1'b1;
			end else if (!esc_seen && c == bcb_pkg::CH_STAR &&
				(comment_on || cmt_in_quote || quote_in_cmt)) begin
				star_wait = 1'b1;
			end else begin
				case (c)
					bcb_pkg::CH_LPAREN: opening = 1'b1;
					bcb_pkg::CH_RPAREN: opening = 1'b0;
					bcb_pkg::CH_LBRACK: begin
						kind = bcb_pkg::KIND_BRACKET;
						opening = 1'b1;
					end
					bcb_pkg::CH_RBRACK: kind = bcb_pkg::KIND_BRACKET;
					bcb_pkg::CH_LBRACE: begin
						kind = bcb_pkg::KIND_BRACE;
						opening = 1'b1;
					end
					bcb_pkg::CH_RBRACE: kind = bcb_pkg::KIND_BRACE;
					default: is_br = 1'b0;
				endcase
				if (is_br) begin
					if (comment_on || cmt_in_quote)
						rgn = bcb_pkg::REG_COMMENT;
					else if (quote_on || quote_in_cmt)
						rgn = bcb_pkg::REG_QUOTE;
					else
						rgn = bcb_pkg::REG_PLAIN;
					bal_tab[rgn][kind] = opening ? bal_tab[rgn][kind] + 1'b1
						: bal_tab[rgn][kind] - 1'b1;
				end
				esc_seen = 1'b0;
			end
		end
		if (last) begin
			for (int k = 0; k < 3; k++) begin
				sum = bal_tab[bcb_pkg::REG_PLAIN][k] + bal_tab[bcb_pkg::REG_QUOTE][k]
					+ bal_tab[bcb_pkg::REG_COMMENT][k];
				bad[k] = (sum != '0);
			end
			v = {bad[bcb_pkg::KIND_PAREN], bad[bcb_pkg::KIND_BRACKET],
				bad[bcb_pkg::KIND_BRACE], ~|bad};
			clear_scan();
		end
		return last;
	endfunction

	function automatic logic [7:0] mark_char(input int unsigned sel);
		case (sel)
			0: mark_char = bcb_pkg::CH_LPAREN;
			1: mark_char = bcb_pkg::CH_RPAREN;
			2: mark_char = bcb_pkg::CH_LBRACK;
			3: mark_char = bcb_pkg::CH_RBRACK;
			4: mark_char = bcb_pkg::CH_LBRACE;
			5: mark_char = bcb_pkg::CH_RBRACE;
			6: mark_char = bcb_pkg::CH_QUOTE;
			7: mark_char = bcb_pkg::CH_SLASH;
			8: mark_char = bcb_pkg::CH_STAR;
			default: mark_char = bcb_pkg::CH_BSLASH;
		endcase
	endfunction

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			draft_q.push_back(s[i]);
	endtask

	// brackets mixed with letters, nothing that changes the scanner mode
	task automatic add_body(input int n);
		repeat (n) begin
			if ($urandom_range(0, 1))
				draft_q.push_back(mark_char($urandom_range(0, 5)));
			else
				draft_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
		end
	endtask

	task automatic push_draft(input bit calm, input bit drain);
		text_word_t w;
		for (int i = 0; i < draft_q.size(); i++) begin
			w.ch = draft_q[i];
			w.last = (i == draft_q.size() - 1);
			w.calm = calm;
			w.drain = drain && (i == 0);
			pend_q.push_back(w);
		end
		draft_q.delete();
	endtask

	// sender: next word goes out at the falling edge
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			if (in_taken)
				tx_wait = cur.calm ? 0 : $urandom_range(0, 8);
			if (tx_wait > 0) begin
				tx_wait--;
				in_valid <= 1'b0;
			end else if (pend_q.size() != 0 && (!pend_q[0].drain || verdict_q.size() == 0)) begin
				cur = pend_q.pop_front();
				in_valid <= 1'b1;
				text_byte <= cur.ch;
				end_of_text <= cur.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: per-result stall, plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (out_valid && rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : scoreboard
		verdict_t v;
		verdict_t got;
		verdict_t want;
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken) begin
			words_in++;
			if (scan_byte(text_byte, end_of_text, v))
				verdict_q.push_back(v);
		end
		if (arst_n && out_valid && out_ready) begin
			got = {paren_unmatched, bracket_unmatched, brace_unmatched, all_matched};
			results_seen++;
			if (verdict_q.size() == 0) begin
				flag_error($sformatf("result %0d arrived with none expected", results_seen));
			end else begin
				want = verdict_q.pop_front();
				for (int i = 0; i < 4; i++)
					if (got[i] !== want[i])
						flag_error($sformatf("result %0d %s is %b, expected %b", results_seen,
							fld_names[i], got[i], want[i]));
			end
			if ($urandom_range(0, 19) == 0)
				rx_calm = !rx_calm;
			rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL c_bracket_balance_checker_core");
				$finish;
			end
		end
	end

	initial begin
		int rand_items;
		arst_n = 1'b0;
		clear_scan();

		// open paren and bracket left, top byte value as the last byte
		add_str("([");
		draft_q.push_back(8'hFF);
		push_draft(1'b0, 1'b0);
		// closers only, zero byte last
		add_str(")]}");
		draft_q.push_back(8'h00);
		push_draft(1'b0, 1'b0);
		// escaped quote and a comment inside a quote, all cleared again
		add_str("\"(\\\"/*[*/\"");
		push_draft(1'b0, 1'b0);
		// quote inside a comment, closer wipes both, stray paren stays
		add_str("/*\"{*/)");
		push_draft(1'b0, 1'b0);
		// slash not followed by star, escaped star, slash left pending
		add_str("/x\\*(/");
		push_draft(1'b0, 1'b0);
		// star left pending inside an open comment
		add_str("/*(*");
		push_draft(1'b0, 1'b0);

		rand_items = 0;
		while (rand_items < 750) begin
			if ($urandom_range(0, 9) < 7) begin
				repeat ($urandom_range(1, 5)) begin
					case ($urandom_range(0, 6))
						0: add_body($urandom_range(1, 4));
						1: begin
							draft_q.push_back(bcb_pkg::CH_QUOTE);
							add_body($urandom_range(0, 3));
							draft_q.push_back(bcb_pkg::CH_QUOTE);
						end
						2: begin
							add_str("/*");
							add_body($urandom_range(0, 3));
							add_str("*/");
						end
						3: begin
							draft_q.push_back(bcb_pkg::CH_BSLASH);
							draft_q.push_back(mark_char($urandom_range(0, 9)));
						end
						4: begin
							draft_q.push_back(bcb_pkg::CH_QUOTE);
							add_body($urandom_range(0, 2));
							add_str("/*");
							add_body($urandom_range(0, 2));
							add_str("*/");
							add_body($urandom_range(0, 2));
							draft_q.push_back(bcb_pkg::CH_QUOTE);
						end
						5: begin
							add_str("/*");
							add_body($urandom_range(0, 2));
							draft_q.push_back(bcb_pkg::CH_QUOTE);
							add_body($urandom_range(0, 2));
							add_str("*/");
						end
						default: begin
							draft_q.push_back(mark_char($urandom_range(7, 8)));
							add_body($urandom_range(1, 3));
						end
					endcase
				end
			end else begin
				repeat ($urandom_range(1, 20))
					draft_q.push_back($urandom_range(0, 1) ? 8'($urandom)
						: mark_char($urandom_range(0, 9)));
			end
			rand_items += draft_q.size();
			push_draft($urandom_range(0, 3) == 0,
				rand_items == draft_q.size() || $urandom_range(0, 19) == 0);
		end

		total_words = pend_q.size();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_in != total_words || verdict_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("PASS c_bracket_balance_checker_core");
		else
			$display("FAIL c_bracket_balance_checker_core");
		$finish;
	end

endmodule
